@@ hw/rtl/bmorph_pkg.sv @@
// Shared types and constants for the 3x3 binary morphology block.
package bmorph_pkg;

  localparam int unsigned DIM_W          = 11;
  localparam int unsigned MASK_W         = 9;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned LINE_W         = 2;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 11;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd1024;
  localparam logic [MASK_W-1:0] RST_MASK   = 9'd186;
  localparam logic              RST_ERODE  = 1'b1;

  localparam logic [PIX_W-1:0] PIX_FG = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BG = 8'h00;

  // Window bit 3*row+col; row 0 above the centre, column 0 to its left.
  localparam logic [MASK_W-1:0] WIN_LEFT   = 9'h049;
  localparam logic [MASK_W-1:0] WIN_RIGHT  = 9'h124;
  localparam logic [MASK_W-1:0] WIN_TOP    = 9'h007;
  localparam logic [MASK_W-1:0] WIN_BOTTOM = 9'h1C0;
  localparam logic [MASK_W-1:0] WIN_KEEP   = 9'h0DB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 4'd0,
    CFG_HEIGHT = 4'd1,
    CFG_MASK   = 4'd2,
    CFG_ERODE  = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // Control carried from the accept stage to the window stage.
  typedef struct packed {
    logic              fg;
    logic              row_ge1;
    logic              row_ge2;
    logic              produce;
    logic              last;
    logic [MASK_W-1:0] kill;
  } stage_t;

endpackage

@@ hw/rtl/bmorph_if.sv @@
// Handshake interfaces for the pixel, result and configuration channels.
interface bmorph_pix_if;
  import bmorph_pkg::*;
  logic             valid;
  logic             ready;
  op_e              operation;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, operation, pixel_value, input ready);
  modport sink   (input valid, operation, pixel_value, output ready);
endinterface

interface bmorph_res_if;
  import bmorph_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] result_pixel;
  logic             frame_last;
  modport source (output valid, result_pixel, frame_last, input ready);
  modport sink   (input valid, result_pixel, frame_last, output ready);
endinterface

interface bmorph_cfg_if;
  import bmorph_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bmorph_line_mem.sv @@
// Two-row line store: one synchronous RAM, one write and one read port, write forwarding.
module bmorph_line_mem #(
  parameter int unsigned DEPTH = bmorph_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr_i,
  output logic [bmorph_pkg::LINE_W-1:0]   rd_data_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr_i,
  input  logic [bmorph_pkg::LINE_W-1:0]   wr_data_i
);
  import bmorph_pkg::*;

  logic [LINE_W-1:0] mem_q [DEPTH];
  logic [LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A read of the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/binary_morphology_3x3_core.sv @@
// Top level of the streaming 3x3 binary erosion and dilation block.
//
//   channel  modport  moves                          per transfer
//   pix_i    sink     operation, pixel_value         one pixel or flush tick
//   res_o    source   result_pixel, frame_last       one result (0 or 255)
//   cfg_i    sink     index, data                    one register write
//
// One item per cycle is sustained while the output is not held; a taken item goes with its
// synchronous line store read into the window stage, then its result into the output register.
// Reset clears the counters, the window and the valid flags; the line store holds
// no reset state, since a row is always written before it is read within a frame.
// A result held in the output register stalls input only when the window stage
// also holds an item that makes a result; configuration writes are always taken.
module binary_morphology_3x3_core #(
  parameter int unsigned MAX_WIDTH  = bmorph_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bmorph_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bmorph_pix_if.sink          pix_i,
  bmorph_res_if.source        res_o,
  bmorph_cfg_if.sink          cfg_i
);
  import bmorph_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned TOT_W = WC_W + ROW_W;

  // Configuration registers.
  logic [DIM_W-1:0]  cfg_w_q, cfg_h_q;
  logic [MASK_W-1:0] cfg_mask_q;
  logic              cfg_erode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= RST_WIDTH;
      cfg_h_q     <= RST_HEIGHT;
      cfg_mask_q  <= RST_MASK;
      cfg_erode_q <= RST_ERODE;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_WIDTH:  cfg_w_q     <= cfg_i.data[DIM_W-1:0];
        CFG_HEIGHT: cfg_h_q     <= cfg_i.data[DIM_W-1:0];
        CFG_MASK:   cfg_mask_q  <= cfg_i.data[MASK_W-1:0];
        CFG_ERODE:  cfg_erode_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, larger than MAX_WIDTH or MAX_HEIGHT saturates.
  logic [WC_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [TOT_W-1:0] total;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WC_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = WC_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg_h_q);
    end
  end

  assign total = TOT_W'(w_eff) * TOT_W'(h_eff);

  // Frame position counters, advanced at the accept edge.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [TOT_W-1:0] emit_q, emit_d;

  // Window stage.
  logic              s1_valid_q;
  stage_t            s1_q, s0_ctl;
  logic [COL_W-1:0]  s1_col_q;
  logic [MASK_W-1:0] win_q, win_d;
  logic              s1_adv;

  // Output register.
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  logic              in_xfer, keep_item, ignore_item, col_zero, cc_zero, cc_right;
  logic              cr_top, cr_bottom, col_end;
  logic [ROW_W-1:0]  cr;
  logic [LINE_W-1:0] rd_data, wr_data;
  logic              up_bit, mid_bit, hit_set;
  logic [MASK_W-1:0] hits;

  assign s1_adv      = s1_valid_q && (!s1_q.produce || !out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer     = pix_i.valid && pix_i.ready;

  always_comb begin
    ignore_item = (pix_i.operation == OP_FLUSH) && (col_q == '0) && (row_q == '0);
    keep_item   = in_xfer && !ignore_item;

    s0_ctl.fg      = (pix_i.operation == OP_PIXEL) && (pix_i.pixel_value != '0) &&
                     (row_q < h_eff);
    s0_ctl.row_ge1 = (row_q != '0);
    s0_ctl.row_ge2 = (row_q >= ROW_W'(2));
    s0_ctl.produce = s0_ctl.row_ge2 || ((row_q == ROW_W'(1)) && (col_q != '0));

    // The result belongs to the pixel one row up and one column back, wrapping to the row above that.
    col_zero  = (col_q == '0);
    cc_zero   = col_zero ? (w_eff == WC_W'(1)) : (col_q == COL_W'(1));
    cc_right  = col_zero || (WC_W'(col_q) >= w_eff);
    cr        = col_zero ? (row_q - ROW_W'(2)) : (row_q - ROW_W'(1));
    cr_top    = (cr == '0);
    cr_bottom = ((ROW_W + 1)'(cr) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);
    s0_ctl.kill = (cc_zero   ? WIN_LEFT   : '0) | (cc_right  ? WIN_RIGHT  : '0) |
                  (cr_top    ? WIN_TOP    : '0) | (cr_bottom ? WIN_BOTTOM : '0);
    s0_ctl.last = s0_ctl.produce &&
                  (((TOT_W + 1)'(emit_q) + (TOT_W + 1)'(1)) >= (TOT_W + 1)'(total));

    col_end = ((WC_W + 1)'(col_q) + (WC_W + 1)'(1)) >= (WC_W + 1)'(w_eff);
    col_d   = col_q;
    row_d   = row_q;
    emit_d  = emit_q;
    if (keep_item) begin
      if (s0_ctl.last) begin
        col_d  = '0;
        row_d  = '0;
        emit_d = '0;
      end else begin
        if (s0_ctl.produce) begin
          emit_d = emit_q + TOT_W'(1);
        end
        if (col_end) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      emit_q <= emit_d;
    end
  end

  bmorph_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (keep_item),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (keep_item) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep_item) begin
      s1_q     <= s0_ctl;
      s1_col_q <= col_q;
    end
  end

  // Upper row bit in entry bit 1, middle row bit in entry bit 0.
  always_comb begin
    up_bit  = s1_q.row_ge2 && rd_data[1];
    mid_bit = s1_q.row_ge1 && rd_data[0];
    wr_data = {mid_bit, s1_q.fg};
    win_d   = ({1'b0, win_q[MASK_W-1:1]} & WIN_KEEP) | (MASK_W'(up_bit) << 2) |
              (MASK_W'(mid_bit) << 5) | (MASK_W'(s1_q.fg) << 8);
    hits    = win_d & ~s1_q.kill & cfg_mask_q;
    hit_set = cfg_erode_q ? (hits == cfg_mask_q) : (hits != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= s1_q.last ? '0 : win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.produce) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.produce) begin
      out_pix_q  <= hit_set ? PIX_FG : PIX_BG;
      out_last_q <= s1_q.last;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_pixel = out_pix_q;
  assign res_o.frame_last   = out_last_q;

  // The final result of a frame returns the position counters to the frame start.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_item && s0_ctl.last |=> (col_q == '0) && (row_q == '0) && (emit_q == '0))
    else $error("counters not cleared after frame end");

  a_window_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.last |=> (win_q == '0))
    else $error("window not cleared after frame end");

  // A line store read that meets the write of the same entry sees the new bits.
  a_line_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_item && s1_adv && (col_q == s1_col_q) |=> (rd_data == $past(wr_data)))
    else $error("line store forwarding lost");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_q.produce))
    else $error("result raised without a producing window step");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the streaming 3x3 binary erosion and dilation core.
module tb_top;
  import bmorph_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1750;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } morph_res_t;

  // Tracks the frame position, the two line stores and the window, and queues the
  // result, if any, that each accepted pixel or flush tick should produce.
  class morph_scoreboard;
    logic [DIM_W-1:0]  width_reg  = RST_WIDTH;
    logic [DIM_W-1:0]  height_reg = RST_HEIGHT;
    logic [MASK_W-1:0] mask_reg   = RST_MASK;
    logic              erode_reg  = RST_ERODE;
    bit                upper_row [DEF_MAX_WIDTH];
    bit                middle_row [DEF_MAX_WIDTH];
    logic [MASK_W-1:0] window = '0;
    int unsigned       col;
    int unsigned       row;
    int unsigned       emitted;
    int unsigned       errors;
    int unsigned       checked;
    morph_res_t        pending_results [$];

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function int unsigned cur_width();
      return clamp_dim(width_reg, DEF_MAX_WIDTH);
    endfunction

    function int unsigned cur_height();
      return clamp_dim(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function bit mid_frame();
      return col != 0 || row != 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WIDTH:  width_reg = data;
        CFG_HEIGHT: height_reg = data;
        CFG_MASK:   mask_reg = data[MASK_W-1:0];
        CFG_ERODE:  erode_reg = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(op_e op, logic [PIX_W-1:0] value);
      int unsigned w, h, cc, cr;
      bit fg, up, mid, hit;
      logic [MASK_W-1:0] seen;
      morph_res_t res;
      w = cur_width();
      h = cur_height();
      // A flush tick outside a frame is dropped without any effect.
      if (op == OP_FLUSH && !mid_frame()) return;
      fg  = (op == OP_PIXEL) && (value != 0) && (row < h);
      up  = 1'b0;
      mid = 1'b0;
      if (col < DEF_MAX_WIDTH) begin
        if (row >= 2) up = upper_row[col];
        if (row >= 1) mid = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = fg;
      end
      window = ((window >> 1) & WIN_KEEP) | {fg, 2'b00, mid, 2'b00, up, 2'b00};
      if (row >= 2 || (row == 1 && col >= 1)) begin
        cc = (col == 0) ? w - 1 : col - 1;
        cr = (col == 0) ? row - 2 : row - 1;
        seen = window;
        if (cc == 0) seen &= ~WIN_LEFT;
        if (cc + 1 >= w) seen &= ~WIN_RIGHT;
        if (cr == 0) seen &= ~WIN_TOP;
        if (cr + 1 >= h) seen &= ~WIN_BOTTOM;
        hit = erode_reg ? ((seen & mask_reg) == mask_reg) : ((seen & mask_reg) != 0);
        res.pixel = hit ? PIX_FG : PIX_BG;
        res.last  = (emitted + 1 >= w * h);
        pending_results = {pending_results, res};
        if (res.last) begin
          window  = '0;
          col     = 0;
          row     = 0;
          emitted = 0;
          return;
        end
        emitted++;
      end
      if (col + 1 >= w) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pixel, logic last);
      morph_res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: none expected, got pixel %0d frame_last %0b",
                   checked, pixel, last);
        return;
      end
      want = pending_results.pop_front();
      if (pixel !== want.pixel || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: pixel exp %0d got %0d, frame_last exp %0b got %0b",
                   checked, want.pixel, pixel, want.last, last);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmorph_pix_if pix ();
  bmorph_res_if res ();
  bmorph_cfg_if cfg ();

  binary_morphology_3x3_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  morph_scoreboard sb = new();

  bit          quiet;
  bit          hold_req;
  int unsigned frame_items;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_dim(int unsigned top);
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, top);
  endfunction

  task automatic send_item(op_e op, logic [PIX_W-1:0] value);
    while (!quiet && $urandom_range(99) < 24) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.operation   <= op;
    pix.pixel_value <= value;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    sb.note_pixel(op, value);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  // Waits until every predicted result has left, then lets the pipeline settle
  // in case it still holds items that make no result.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned mask,
                           int unsigned erode, bit [3:0] sel);
    wait_idle();
    if (sel[0]) write_reg(CFG_WIDTH, w);
    if (sel[1]) write_reg(CFG_HEIGHT, h);
    if (sel[2]) write_reg(CFG_MASK, mask);
    if (sel[3]) write_reg(CFG_ERODE, erode);
    cfg.valid <= 1'b0;
  endtask

  // Streams the current frame to its end, or stops early after stop_after
  // transfers when that is non-zero. Noisy frames carry flush ticks inside the
  // image and real pixels during the drain.
  task automatic run_frame(int unsigned fg_pct, bit noisy, int unsigned stop_after,
                           output int unsigned sent);
    op_e op;
    logic [PIX_W-1:0] value;
    sent = 0;
    do begin
      value = ($urandom_range(99) < fg_pct) ? PIX_W'($urandom_range(1, 255)) : PIX_BG;
      if (sb.row >= sb.cur_height())
        op = (noisy && $urandom_range(2) == 0) ? OP_PIXEL : OP_FLUSH;
      else if (sb.mid_frame())
        op = (noisy && $urandom_range(9) == 0) ? OP_FLUSH : OP_PIXEL;
      else
        op = OP_PIXEL;
      send_item(op, value);
      sent++;
    end while (sb.mid_frame() && sent != stop_after);
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid === 1'b1 && res.ready === 1'b1)
        sb.check_result(res.result_pixel, res.frame_last);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= quiet || ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [PIX_W-1:0] ramp [9] = '{8'hFF, 8'h01, 8'h02, 8'h04, 8'h80,
                                   8'h08, 8'h10, 8'h20, 8'h40};
    int unsigned k, sent, stop_at, mask;
    pix.valid       <= 1'b0;
    pix.operation   <= OP_PIXEL;
    pix.pixel_value <= PIX_BG;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_WIDTH;
    cfg.data        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full mask erosion on a 3x3 image: only the centre survives the border.
    configure(3, 3, 9'h1FF, 1, 4'hF);
    send_item(OP_FLUSH, 8'hA5);
    foreach (ramp[i]) send_item(OP_PIXEL, ramp[i]);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_FLUSH, 8'h7F);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_FLUSH, 8'h00);

    // An empty element under erosion gives foreground everywhere.
    configure(2, 2, 0, 1, 4'hF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_FLUSH, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_PIXEL, 8'h55);

    k = 0;
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS || sb.mid_frame()) begin
      if (sb.mid_frame()) begin
        // Resume a broken frame under new settings; the row may only get shorter,
        // so that no line store entry is read before this frame wrote it.
        configure($urandom_range(sb.cur_width() < 12 ? sb.cur_width() : 12), pick_dim(8),
                  $urandom_range(511), $urandom_range(1), 4'($urandom_range(1, 15)));
        run_frame($urandom_range(5, 95), 1'b1, 0, sent);
        frame_items += sent;
      end else begin
        k++;
        mask = $urandom_range(511);
        if ($urandom_range(7) == 0) mask = 0;
        else if ($urandom_range(7) == 0) mask = 9'h1FF;
        stop_at = 0;
        case (k)
          2: begin
            configure(10, 4, mask, $urandom_range(1), 4'hF);
            hold_req = 1'b1;
          end
          4: begin
            configure(16, 8, mask, $urandom_range(1), 4'hF);
            quiet = 1'b1;
          end
          6: begin
            configure(0, 2047, mask, $urandom_range(1), 4'hF);
            stop_at = 200;
          end
          8: begin
            configure(2047, 0, mask, $urandom_range(1), 4'hF);
            stop_at = 1040;
          end
          default: begin
            configure(pick_dim(12), pick_dim(8), mask, $urandom_range(1),
                      4'($urandom_range(1, 15)));
            if ($urandom_range(4) == 0)
              stop_at = $urandom_range(1, sb.cur_width() * sb.cur_height());
          end
        endcase
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) send_item(OP_FLUSH, PIX_W'($urandom_range(255)));
        run_frame($urandom_range(5, 95), $urandom_range(3) == 0, stop_at, sent);
        frame_items += sent;
        quiet = 1'b0;
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ binary_morphology_3x3_core.f @@
hw/rtl/bmorph_pkg.sv
hw/rtl/bmorph_if.sv
hw/rtl/bmorph_line_mem.sv
hw/rtl/binary_morphology_3x3_core.sv
dv/tb_top.sv
